FILE: rtl/iqd_pkg.sv
// Shared constants, types and carrier/rounding functions for the IQ demodulator.
// Depends on nothing; imported by iqd_fir_lane, iq_mixer_lowpass_demodulator and the testbench.
package iqd_pkg;

	localparam int FRAME_SAMPLES   = 512;
	localparam int TAP_COUNT       = 27;
	localparam int SINE_TABLE_BITS = 10;

	localparam int SAMPLE_W   = 16;
	localparam int PROD_W     = 2 * SAMPLE_W;
	localparam int ACC_W      = PROD_W + 1;
	localparam int COEF_W     = 12;
	localparam int TAP_IDX_W  = $clog2(TAP_COUNT);
	localparam int FRAME_W    = $clog2(FRAME_SAMPLES);
	localparam int PHASE_W    = 32;
	localparam int QBITS      = SINE_TABLE_BITS - 2;
	localparam int QUARTER    = 1 << QBITS;
	localparam int FRAC_BITS  = 15;

	// Configuration port
	localparam int  CFG_ADDR_W = 3;
	localparam int  CFG_DATA_W = 32;
	localparam logic REG_PHASE_STEP = 1'b0;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	// Lane control: shift_in pushes a new mixed value, rotate turns the line by one place
	typedef struct packed {
		logic shift_in;
		logic rotate;
	} lane_ctrl_t;

	localparam logic [COEF_W-1:0] LP_COEF [TAP_COUNT] = '{
		12'd511, 12'd670, 12'd831, 12'd992, 12'd1150, 12'd1301, 12'd1443,
		12'd1573, 12'd1688, 12'd1785, 12'd1863, 12'd1920, 12'd1954, 12'd1966,
		12'd1954, 12'd1920, 12'd1863, 12'd1785, 12'd1688, 12'd1573, 12'd1443,
		12'd1301, 12'd1150, 12'd992, 12'd831, 12'd670, 12'd511
	};

	// Quarter-wave sine magnitudes, Q1.15, entries 0 .. QUARTER inclusive
	typedef logic [QUARTER:0][SAMPLE_W-1:0] qtab_t;

	function automatic qtab_t build_qsin();
		qtab_t t;
		longint unsigned u;
		longint unsigned u2;
		longint unsigned p;
		longint unsigned v;
		int k;
		t = '0;
		for (k = 0; k <= QUARTER; k++) begin
			u  = longint'(k) << (30 - QBITS);
			u2 = (u * u) >> 30;
			p  = 64'd3864;
			p  = 64'd172272 - ((p * u2) >> 30);
			p  = 64'd5026995 - ((p * u2) >> 30);
			p  = 64'd85569306 - ((p * u2) >> 30);
			p  = 64'd693598668 - ((p * u2) >> 30);
			p  = 64'd1686629713 - ((p * u2) >> 30);
			v  = (((p * u) >> 30) + 64'd16384) >> 15;
			if (v > 64'd32767)
				v = 64'd32767;
			t[k] = v[SAMPLE_W-1:0];
		end
		return t;
	endfunction

	localparam qtab_t QSIN = build_qsin();

	// Signed Q1.15 sine of a table index
	function automatic sample_t table_sine(input logic [SINE_TABLE_BITS-1:0] idx);
		logic [1:0]       quad;
		logic [QBITS-1:0] r;
		logic [QBITS:0]   k;
		sample_t          m;
		quad = idx[SINE_TABLE_BITS-1 -: 2];
		r    = idx[QBITS-1:0];
		k    = quad[0] ? ((QBITS+1)'(QUARTER) - {1'b0, r}) : {1'b0, r};
		m    = sample_t'(QSIN[k]);
		return quad[1] ? -m : m;
	endfunction

	// Round half up from Q.30 to Q.15 and saturate to 16 bits
	function automatic sample_t round_sat15(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W:0]           t;
		logic signed [ACC_W-FRAC_BITS:0] q;
		t = (ACC_W+1)'(v) + (ACC_W+1)'(1 << (FRAC_BITS - 1));
		q = t[ACC_W:FRAC_BITS];
		if (q[ACC_W-FRAC_BITS:SAMPLE_W-1] != {(ACC_W-FRAC_BITS-SAMPLE_W+2){q[SAMPLE_W-1]}})
			return q[ACC_W-FRAC_BITS] ? sample_t'(16'sh8000) : sample_t'(16'sh7FFF);
		return q[SAMPLE_W-1:0];
	endfunction

endpackage

FILE: rtl/iqd_fir_lane.sv
// FIR delay line for one channel: pushes mixed values in and rotates during the MAC pass.
// Depends on iqd_pkg.
module iqd_fir_lane
	import iqd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  lane_ctrl_t ctrl,
	input  sample_t    din,
	output sample_t    tail
);

	sample_t hist_q [TAP_COUNT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TAP_COUNT; i++)
				hist_q[i] <= '0;
		end else if (ctrl.shift_in || ctrl.rotate) begin
			hist_q[0] <= ctrl.shift_in ? din : hist_q[TAP_COUNT-1];
			for (int i = 1; i < TAP_COUNT; i++)
				hist_q[i] <= hist_q[i-1];
		end
	end

	assign tail = hist_q[TAP_COUNT-1];

endmodule

FILE: rtl/iq_mixer_lowpass_demodulator.sv
// IQ mixer and low-pass demodulator: carrier lookup, mixing and two 27-tap FIRs.
// One item at a time (a new sample is taken only in idle): accept, carrier lookup,
// 2 mixing products and 54 tap MACs on the single shared 16x16 multiplier, then done,
// which holds while the previous result is still stalled, then raises result_valid.
// Reset (arst_n, async, low) clears phase, frame position, phase_step and both
// FIR histories; no clearing pass is needed.
module iq_mixer_lowpass_demodulator
	import iqd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration port
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready,
	// sample channel
	input  logic                  sample_valid,
	output logic                  sample_stall,
	input  sample_t               sample,
	// result channel
	output logic                  result_valid,
	input  logic                  result_stall,
	output sample_t               in_phase,
	output sample_t               quadrature,
	output logic                  frame_last
);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_CARR  = 7'b0000010,
		S_MIX_I = 7'b0000100,
		S_MIX_Q = 7'b0001000,
		S_FIR_I = 7'b0010000,
		S_FIR_Q = 7'b0100000,
		S_DONE  = 7'b1000000
	} state_t;

	state_t                    state_q;
	logic [PHASE_W-1:0]        phase_step_q;
	logic [PHASE_W-1:0]        phase_q;
	logic [FRAME_W-1:0]        pos_q;
	logic [TAP_IDX_W-1:0]      tap_q;
	logic signed [ACC_W-1:0]   acc_q;
	sample_t                   sample_q;
	sample_t                   sin_q;
	sample_t                   cos_q;
	sample_t                   yi_q;
	sample_t                   yq_q;
	logic                      result_valid_q;
	sample_t                   in_phase_q;
	sample_t                   quadrature_q;
	logic                      frame_last_q;

	logic                      cfg_write;
	logic                      sample_take;
	logic                      out_free;
	logic                      last_tap;
	logic                      frame_end;
	logic [SINE_TABLE_BITS-1:0] sin_idx;
	logic [SINE_TABLE_BITS-1:0] cos_idx;
	sample_t                   mul_a;
	sample_t                   mul_b;
	logic signed [PROD_W-1:0]  prod;
	logic signed [ACC_W-1:0]   acc_sum;
	sample_t                   mix_val;
	sample_t                   coef_op;
	sample_t                   i_tail;
	sample_t                   q_tail;
	lane_ctrl_t                i_ctrl;
	lane_ctrl_t                q_ctrl;

	// ---------------------------------------------------------------
	// Configuration port: zero wait states, word-addressed
	// ---------------------------------------------------------------
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_q <= '0;
		end else if (cfg_write && paddr[CFG_ADDR_W-1] == REG_PHASE_STEP) begin
			phase_step_q <= pwdata;
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[CFG_ADDR_W-1] == REG_PHASE_STEP)
			prdata = phase_step_q;
	end

	// ---------------------------------------------------------------
	// Handshakes: take a sample only in idle; the result register frees
	// as soon as its item is taken downstream.
	// ---------------------------------------------------------------
	assign sample_stall = (state_q != S_IDLE);
	assign sample_take  = sample_valid && !sample_stall;
	assign out_free     = !result_valid_q || !result_stall;
	assign last_tap     = (tap_q == TAP_IDX_W'(TAP_COUNT - 1));
	assign frame_end    = (pos_q == FRAME_W'(FRAME_SAMPLES - 1));

	// Carrier indexes: the top phase bits, cosine a quarter turn ahead
	assign sin_idx = phase_q[PHASE_W-1 -: SINE_TABLE_BITS];
	assign cos_idx = sin_idx + SINE_TABLE_BITS'(QUARTER);

	// ---------------------------------------------------------------
	// Shared multiplier: mixing products first, then the tap MACs.
	// The lane tail holds tap TAP_COUNT-1-t after t rotations.
	// ---------------------------------------------------------------
	assign coef_op = sample_t'({{(SAMPLE_W-COEF_W){1'b0}},
		LP_COEF[TAP_IDX_W'(TAP_COUNT - 1) - tap_q]});

	always_comb begin
		mul_a = sample_q;
		mul_b = cos_q;
		unique case (state_q)
			S_MIX_I: begin
				mul_a = sample_q;
				mul_b = cos_q;
			end
			S_MIX_Q: begin
				mul_a = sample_q;
				mul_b = sin_q;
			end
			S_FIR_I: begin
				mul_a = i_tail;
				mul_b = coef_op;
			end
			S_FIR_Q: begin
				mul_a = q_tail;
				mul_b = coef_op;
			end
			default: begin
				mul_a = sample_q;
				mul_b = cos_q;
			end
		endcase
	end

	assign prod    = mul_a * mul_b;
	assign acc_sum = acc_q + ACC_W'(prod);
	assign mix_val = round_sat15(ACC_W'(prod));

	// Lane control: push in the mix states, rotate once per MAC
	always_comb begin
		i_ctrl          = '0;
		q_ctrl          = '0;
		i_ctrl.shift_in = (state_q == S_MIX_I);
		q_ctrl.shift_in = (state_q == S_MIX_Q);
		i_ctrl.rotate   = (state_q == S_FIR_I);
		q_ctrl.rotate   = (state_q == S_FIR_Q);
	end

	iqd_fir_lane u_lane_i (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (i_ctrl),
		.din    (mix_val),
		.tail   (i_tail)
	);

	iqd_fir_lane u_lane_q (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (q_ctrl),
		.din    (mix_val),
		.tail   (q_tail)
	);

	// ---------------------------------------------------------------
	// Sequencer
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			tap_q   <= '0;
			phase_q <= '0;
			pos_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (sample_take)
						state_q <= S_CARR;
				end
				S_CARR:  state_q <= S_MIX_I;
				S_MIX_I: state_q <= S_MIX_Q;
				S_MIX_Q: begin
					tap_q   <= '0;
					state_q <= S_FIR_I;
				end
				S_FIR_I: begin
					if (last_tap) begin
						tap_q   <= '0;
						state_q <= S_FIR_Q;
					end else begin
						tap_q <= tap_q + 1'b1;
					end
				end
				S_FIR_Q: begin
					if (last_tap) begin
						tap_q   <= '0;
						state_q <= S_DONE;
					end else begin
						tap_q <= tap_q + 1'b1;
					end
				end
				S_DONE: begin
					// Hold until the result register is free, then advance the carrier (restart it at frame end)
					if (out_free) begin
						state_q <= S_IDLE;
						if (frame_end) begin
							pos_q   <= '0;
							phase_q <= '0;
						end else begin
							pos_q   <= pos_q + 1'b1;
							phase_q <= phase_q + phase_step_q;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers (no reset)
	always_ff @(posedge clk) begin
		if (sample_take)
			sample_q <= sample;
		if (state_q == S_CARR) begin
			sin_q <= table_sine(sin_idx);
			cos_q <= table_sine(cos_idx);
		end
		if (state_q == S_MIX_Q)
			acc_q <= '0;
		if (state_q == S_FIR_I || state_q == S_FIR_Q)
			acc_q <= last_tap ? '0 : acc_sum;
		if (state_q == S_FIR_I && last_tap)
			yi_q <= round_sat15(acc_sum);
		// Keep Q aside so a result still waiting downstream stays intact
		if (state_q == S_FIR_Q && last_tap)
			yq_q <= round_sat15(acc_sum);
		if (state_q == S_DONE && out_free) begin
			in_phase_q   <= yi_q;
			quadrature_q <= yq_q;
			frame_last_q <= frame_end;
		end
	end

	// Result valid: set on load, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	assign result_valid = result_valid_q;
	assign in_phase     = in_phase_q;
	assign quadrature   = quadrature_q;
	assign frame_last   = frame_last_q;

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	a_valid_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(state_q == S_DONE))
		else $error("result valid rose outside the done state");

	a_take_starts_carrier: assert property (@(posedge clk) disable iff (!arst_n)
		sample_take |=> (state_q == S_CARR))
		else $error("accepted sample did not start the carrier step");

	a_tap_range: assert property (@(posedge clk) disable iff (!arst_n)
		tap_q <= TAP_IDX_W'(TAP_COUNT - 1))
		else $error("tap counter ran past the last tap");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= FRAME_W'(FRAME_SAMPLES - 1))
		else $error("frame position ran past the frame");

	a_frame_start_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(pos_q == '0) |-> (phase_q == '0))
		else $error("carrier phase not zero at frame start");

endmodule

FILE: bench/tb_iq_mixer_lowpass_demodulator.sv
// Testbench for iq_mixer_lowpass_demodulator: APB setup of phase_step, sample items
// in and I/Q results out, each result checked against an in-bench demodulator model.
// Depends on iqd_pkg (sizes, sample_t, register index) and the RTL top level.
module tb_iq_mixer_lowpass_demodulator
	import iqd_pkg::*;
;

	// Generous: about 1800 items plus idling fit well within this limit.
	localparam int CYCLE_LIMIT = 1_000_000;
	// Tail after the last result.
	localparam int TAIL_CYCLES = 120;
	localparam int ITEMS_PER_PHASE = 300;

	// Byte addresses: register index times four.
	localparam logic [CFG_ADDR_W-1:0] ADDR_PHASE_STEP = {REG_PHASE_STEP, 2'b00};
	localparam logic [CFG_ADDR_W-1:0] ADDR_UNMAPPED   = {~REG_PHASE_STEP, 2'b00};

	// Window-sinc low-pass taps in Q1.15, newest sample first.
	localparam int LPF_TAPS [TAP_COUNT] = '{
		511, 670, 831, 992, 1150, 1301, 1443, 1573, 1688, 1785, 1863, 1920, 1954,
		1966,
		1954, 1920, 1863, 1785, 1688, 1573, 1443, 1301, 1150, 992, 831, 670, 511
	};

	typedef struct {
		sample_t in_phase;
		sample_t quadrature;
		logic    frame_last;
	} iq_result_t;

	// Kinds of random stretches
	typedef enum int {
		STRETCH_TONE,
		STRETCH_NOISE,
		STRETCH_RAIL,
		STRETCH_TINY,
		STRETCH_TOGGLE
	} stretch_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [CFG_DATA_W-1:0] pwdata;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  sample_valid;
	logic                  sample_stall;
	sample_t               sample;
	logic                  result_valid;
	logic                  result_stall = 1'b0;
	sample_t               in_phase;
	sample_t               quadrature;
	logic                  frame_last;

	// Model state: carrier accumulator, frame counter and the two FIR delay lines
	logic [PHASE_W-1:0] nco_step;
	logic [PHASE_W-1:0] nco_phase;
	int                 frame_pos;
	int                 i_line [TAP_COUNT];
	int                 q_line [TAP_COUNT];

	iq_result_t iq_expected [$];
	iq_result_t want;
	int         errors;
	int         cycle_count;
	int         src_idle_pct;
	int         sink_stall_pct;

	iq_mixer_lowpass_demodulator uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.in_phase     (in_phase),
		.quadrature   (quadrature),
		.frame_last   (frame_last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------------
	// Model
	// ---------------------------------------------------------------------

	// Q1.15 sine of a carrier table index. A quarter wave is evaluated as an
	// odd degree-11 polynomial in Q2.30 (Horner, each product truncated), then
	// rounded half up, clamped to +32767 and given the quadrant's sign.
	function automatic int carrier_sine(input logic [SINE_TABLE_BITS-1:0] idx);
		logic [1:0]        quad;
		logic [QBITS-1:0]  r;
		longint unsigned   u;
		longint unsigned   u2;
		longint unsigned   p;
		longint unsigned   v;
		quad = idx[SINE_TABLE_BITS-1 -: 2];
		r    = idx[QBITS-1:0];
		u    = 64'(r) << (30 - QBITS);
		if (quad[0])
			u = (64'd1 << 30) - u;
		u2 = (u * u) >> 30;
		p  = 64'd3864;
		p  = 64'd172272 - ((p * u2) >> 30);
		p  = 64'd5026995 - ((p * u2) >> 30);
		p  = 64'd85569306 - ((p * u2) >> 30);
		p  = 64'd693598668 - ((p * u2) >> 30);
		p  = 64'd1686629713 - ((p * u2) >> 30);
		v  = (((p * u) >> 30) + 64'd16384) >> 15;
		if (v > 64'd32767)
			v = 64'd32767;
		return quad[1] ? -int'(v) : int'(v);
	endfunction

	// Q.30 to Q1.15: add half an LSB, floor shift, clamp to 16 bits.
	function automatic int round_q15(input longint v);
		longint q;
		q = (v + 64'sd16384) >>> 15;
		if (q > 32767)
			q = 32767;
		if (q < -32768)
			q = -32768;
		return int'(q);
	endfunction

	// Shift a mixed value into a delay line and return the filtered output.
	function automatic int lowpass_push(ref int line [TAP_COUNT], input int x);
		longint acc;
		acc = 0;
		for (int k = TAP_COUNT - 1; k > 0; k--)
			line[k] = line[k-1];
		line[0] = x;
		for (int k = 0; k < TAP_COUNT; k++)
			acc += longint'(LPF_TAPS[k]) * longint'(line[k]);
		return round_q15(acc);
	endfunction

	// Advance the model by one accepted sample and queue the I/Q it yields.
	function automatic void predict_iq_result(input sample_t s);
		logic [SINE_TABLE_BITS-1:0] idx;
		logic [SINE_TABLE_BITS-1:0] cos_idx;
		int                         sn;
		int                         cs;
		iq_result_t                 r;
		idx     = nco_phase[PHASE_W-1 -: SINE_TABLE_BITS];
		cos_idx = idx + SINE_TABLE_BITS'(QUARTER);
		sn      = carrier_sine(idx);
		cs      = carrier_sine(cos_idx);
		r.in_phase   = sample_t'(lowpass_push(i_line, round_q15(longint'(s) * cs)));
		r.quadrature = sample_t'(lowpass_push(q_line, round_q15(longint'(s) * sn)));
		frame_pos++;
		if (frame_pos >= FRAME_SAMPLES) begin
			// Frame end: restart the carrier, histories carry over
			frame_pos    = 0;
			nco_phase    = '0;
			r.frame_last = 1'b1;
		end else begin
			nco_phase    = nco_phase + nco_step;
			r.frame_last = 1'b0;
		end
		iq_expected.push_back(r);
	endfunction

	// ---------------------------------------------------------------------
	// Result checking and watchdog
	// ---------------------------------------------------------------------

	// Random backpressure on the result side, redrawn every cycle.
	always @(posedge clk)
		result_stall <= ($urandom_range(99) < sink_stall_pct);

	// Compare every accepted result with the oldest outstanding prediction.
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (iq_expected.size() == 0) begin
				$error("unexpected result: in_phase %0d quadrature %0d frame_last %0d",
					in_phase, quadrature, frame_last);
				errors++;
			end else begin
				want = iq_expected.pop_front();
				if (in_phase !== want.in_phase) begin
					$error("in_phase: expected %0d, got %0d", want.in_phase, in_phase);
					errors++;
				end
				if (quadrature !== want.quadrature) begin
					$error("quadrature: expected %0d, got %0d", want.quadrature, quadrature);
					errors++;
				end
				if (frame_last !== want.frame_last) begin
					$error("frame_last: expected %0d, got %0d", want.frame_last, frame_last);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$error("timeout with %0d results outstanding", iq_expected.size());
			$display("iq_mixer_lowpass_demodulator: mismatch");
			$finish;
		end
	end

	// ---------------------------------------------------------------------
	// Drivers
	// ---------------------------------------------------------------------

	// One APB transfer: setup phase, access phase until pready, then an idle wait so the
	// next transfer never raises psel in the step that lowered it.
	task automatic apb_transfer(input logic wr, input logic [CFG_ADDR_W-1:0] addr,
			input logic [CFG_DATA_W-1:0] wdata, output logic [CFG_DATA_W-1:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= addr;
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		rdata = prdata;
		if (wr && addr == ADDR_PHASE_STEP)
			nco_step = wdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// Write phase_step and read it back.
	task automatic set_phase_step(input logic [PHASE_W-1:0] step);
		logic [CFG_DATA_W-1:0] rd;
		apb_transfer(1'b1, ADDR_PHASE_STEP, step, rd);
		apb_transfer(1'b0, ADDR_PHASE_STEP, '0, rd);
		if (rd !== step) begin
			$error("phase_step: expected %0h, got %0h", step, rd);
			errors++;
		end
	endtask

	// Offer one sample item, idling first at the current rate; hold it until taken.
	task automatic send_sample(input sample_t s);
		while ($urandom_range(99) < src_idle_pct) begin
			sample_valid <= 1'b0;
			@(posedge clk);
		end
		sample_valid <= 1'b1;
		sample       <= s;
		do
			@(posedge clk);
		while (sample_stall);
		predict_iq_result(s);
	endtask

	// Drop valid and hold off until every predicted result has been taken.
	task automatic wait_drained();
		sample_valid <= 1'b0;
		@(posedge clk);
		while (iq_expected.size() != 0)
			@(posedge clk);
	endtask

	// ---------------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------------

	// Reset value, write and read back, and a write to an unmapped index that
	// must leave phase_step alone.
	task automatic test_register_access();
		logic [CFG_DATA_W-1:0] rd;
		apb_transfer(1'b0, ADDR_PHASE_STEP, '0, rd);
		if (rd !== '0) begin
			$error("phase_step: expected %0h, got %0h", 32'h0, rd);
			errors++;
		end
		set_phase_step(32'h1234_5678);
		apb_transfer(1'b1, ADDR_UNMAPPED, 32'hA5A5_5A5A, rd);
		apb_transfer(1'b0, ADDR_PHASE_STEP, '0, rd);
		if (rd !== 32'h1234_5678) begin
			$error("phase_step: expected %0h, got %0h", 32'h1234_5678, rd);
			errors++;
		end
	endtask

	// Full-scale input on a still carrier drives the I filter past +1 and into
	// saturation; then the extreme step with the sample rails and zero.
	task automatic test_directed_extremes();
		set_phase_step(32'h0000_0000);
		repeat (22)
			send_sample(sample_t'(16'sh7FFF));
		wait_drained();
		set_phase_step(32'hFFFF_FFFF);
		send_sample(sample_t'(16'sh8000));
		send_sample(sample_t'(16'sh7FFF));
		send_sample(sample_t'(16'sh0000));
		wait_drained();
	endtask

	// Random stretches: tones most often (what the block is built for), plus noise,
	// rail bursts at least as long as the filters, tiny values and toggling.
	task automatic send_random_items(input int count);
		stretch_t           kind;
		int                 run;
		int                 amp;
		int                 v;
		logic [PHASE_W-1:0] tone_phase;
		logic [PHASE_W-1:0] tone_step;
		logic               rail_hi;
		for (int sent = 0; sent < count; ) begin
			case ($urandom_range(9))
				0, 1, 2, 3: kind = STRETCH_TONE;
				4, 5:       kind = STRETCH_NOISE;
				6:          kind = STRETCH_RAIL;
				7:          kind = STRETCH_TINY;
				default:    kind = STRETCH_TOGGLE;
			endcase
			run        = (kind == STRETCH_RAIL) ? $urandom_range(30, 40) : $urandom_range(8, 60);
			amp        = $urandom_range(32767);
			tone_phase = $urandom();
			tone_step  = $urandom_range(1) ? nco_step : $urandom();
			rail_hi    = $urandom_range(1);
			for (int k = 0; k < run && sent < count; k++, sent++) begin
				case (kind)
					STRETCH_TONE: begin
						v = (amp * carrier_sine(tone_phase[PHASE_W-1 -: SINE_TABLE_BITS])) >>> 15;
						tone_phase = tone_phase + tone_step;
					end
					STRETCH_NOISE:  v = int'($signed(16'($urandom())));
					STRETCH_RAIL:   v = rail_hi ? 32767 : -32768;
					STRETCH_TINY:   v = $urandom_range(8) - 4;
					default:        v = (k % 2) ? 32767 : -32768;
				endcase
				send_sample(sample_t'(v));
			end
		end
	endtask

	// Six phases of random items, each with its own carrier step; idling moves
	// from sender-light to receiver-light to none. Each phase pauses once
	// halfway until all results are back.
	task automatic test_random_mixing();
		logic [PHASE_W-1:0] steps [6];
		steps = '{32'h0040_0000, 32'hFFFF_FFFF, $urandom(), 32'h4000_0000,
			32'h8000_0000, $urandom()};
		for (int ph = 0; ph < 6; ph++) begin
			case (ph / 2)
				0: begin
					src_idle_pct   = 21;
					sink_stall_pct = 45;
				end
				1: begin
					src_idle_pct   = 45;
					sink_stall_pct = 21;
				end
				default: begin
					src_idle_pct   = 0;
					sink_stall_pct = 0;
				end
			endcase
			wait_drained();
			set_phase_step(steps[ph]);
			send_random_items(ITEMS_PER_PHASE / 2);
			wait_drained();
			send_random_items(ITEMS_PER_PHASE - ITEMS_PER_PHASE / 2);
		end
		wait_drained();
	endtask

	initial begin
		errors         = 0;
		cycle_count    = 0;
		src_idle_pct   = 21;
		sink_stall_pct = 45;
		nco_step       = '0;
		nco_phase      = '0;
		frame_pos      = 0;
		for (int k = 0; k < TAP_COUNT; k++) begin
			i_line[k] = 0;
			q_line[k] = 0;
		end
		arst_n       <= 1'b0;
		psel         <= 1'b0;
		penable      <= 1'b0;
		pwrite       <= 1'b0;
		paddr        <= '0;
		pwdata       <= '0;
		sample_valid <= 1'b0;
		sample       <= '0;
		repeat (11)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_register_access();
		test_directed_extremes();
		test_random_mixing();

		// Hold for anything stray after the last expected result.
		repeat (TAIL_CYCLES)
			@(posedge clk);
		if (errors == 0)
			$display("iq_mixer_lowpass_demodulator: match");
		else
			$display("iq_mixer_lowpass_demodulator: mismatch");
		$finish;
	end

endmodule
